FILE: rtl/itp_pkg.sv
// shared types, codes and the character classifier of the integer text parser
package itp_pkg;

    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned RADIX_W  = 5;
    localparam int unsigned MAXW_W   = 8;
    localparam int unsigned SIZE_W   = 2;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned USED_W   = 10;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [USED_W-1:0] USED_MAX = 10'd1023;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RADIX     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_WIDTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_MODE = 2'd2;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_CONVERTED = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_DIGITS = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_END_FIRST = 2'd2;

    // size modes
    localparam logic [SIZE_W-1:0] SIZE_INT   = 2'd0;
    localparam logic [SIZE_W-1:0] SIZE_SHORT = 2'd1;
    localparam logic [SIZE_W-1:0] SIZE_CHAR  = 2'd2;
    localparam logic [SIZE_W-1:0] SIZE_WIDE  = 2'd3;

    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
    localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
    localparam logic [CHAR_W-1:0] CASE_GAP   = 8'h20;
    localparam logic [CHAR_W-1:0] LETTER_BASE = 8'd10;

    typedef struct packed {
        logic [RADIX_W-1:0] radix;
        logic [MAXW_W-1:0]  max_width;
        logic [SIZE_W-1:0]  size_mode;
    } t_cfg;

    // one classified input transaction
    typedef struct packed {
        logic               eoi;
        logic               is_plus;
        logic               is_minus;
        logic               big;      // digit value 32 or more, or not a digit at all
        logic [RADIX_W-1:0] dig;
    } t_cls;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  value;
        logic [USED_W-1:0]   chars_used;
        logic                pushed_back;
    } t_result;

    function automatic t_cls classify(input logic [CHAR_W-1:0] c, input logic eoi);
        t_cls               r;
        logic [CHAR_W-1:0]  d;
        logic [CHAR_W-1:0]  v;
        r          = '0;
        r.eoi      = eoi;
        r.is_plus  = (c == CH_PLUS);
        r.is_minus = (c == CH_MINUS);
        d = c;
        if (d >= CH_LOWER_A) begin
            d = d - CASE_GAP;
        end
        if (d >= CH_UPPER_A) begin
            v     = d - CH_UPPER_A + LETTER_BASE;
            r.big = (v[CHAR_W-1:RADIX_W] != '0);
            r.dig = v[RADIX_W-1:0];
        end else if (d >= CH_ZERO && d <= CH_NINE) begin
            v     = d - CH_ZERO;
            r.big = 1'b0;
            r.dig = v[RADIX_W-1:0];
        end else begin
            r.big = 1'b1;
            r.dig = '0;
        end
        return r;
    endfunction

endpackage

FILE: rtl/itp_front.sv
// front end: classifies each character and holds it in a two-entry queue
module itp_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic [itp_pkg::CHAR_W-1:0]    i_char_code,
    input  logic                          i_end_of_input,
    output logic                          o_valid,
    output itp_pkg::t_cls                 o_cls,
    input  logic                          i_take
);

    itp_pkg::t_cls r_q [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_count;
    logic          n_wr_ptr;
    logic          n_rd_ptr;
    logic [1:0]    n_count;
    logic          w_wr;
    logic          w_rd;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cls   = r_q[r_rd_ptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_take && o_valid;

    always_comb begin
        n_wr_ptr = w_wr ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = w_rd ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count;
        if (w_wr && !w_rd) begin
            n_count = r_count + 2'd1;
        end else if (w_rd && !w_wr) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wr_ptr] <= itp_pkg::classify(i_char_code, i_end_of_input);
        end
    end

endmodule

FILE: rtl/itp_back.sv
// back end: conversion state machine and the two-entry result queue
module itp_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  itp_pkg::t_cfg        i_cfg,
    input  logic                 i_valid,
    input  itp_pkg::t_cls        i_cls,
    output logic                 o_take,
    output logic                 o_empty,
    input  logic                 i_pop,
    output itp_pkg::t_result     o_result
);

    typedef enum logic [1:0] {
        PH_START,
        PH_SIGNED,
        PH_DIGITS
    } t_phase;

    t_phase                          r_phase, n_phase;
    logic                            r_minus, n_minus;
    logic [itp_pkg::VALUE_W-1:0]     r_acc, n_acc;
    logic [itp_pkg::MAXW_W-1:0]      r_wl, n_wl;
    logic                            r_lim, n_lim;
    logic                            r_any, n_any;
    logic [itp_pkg::USED_W-1:0]      r_used, n_used;

    logic                            w_emit;
    itp_pkg::t_result                w_res;
    logic [itp_pkg::VALUE_W-1:0]     w_mac;
    logic [itp_pkg::VALUE_W-1:0]     w_src;
    logic [itp_pkg::VALUE_W-1:0]     w_val;
    logic                            s_lim;
    logic [itp_pkg::MAXW_W-1:0]      s_wl;
    logic [itp_pkg::USED_W-1:0]      w_used_inc;
    logic                            w_digit_ok;

    itp_pkg::t_result                r_rq [2];
    logic                            r_wr_ptr;
    logic                            r_rd_ptr;
    logic [1:0]                      r_count;
    logic                            w_push;
    logic                            w_pop;

    assign o_take = i_valid && (r_count != 2'd2);

    assign w_mac = (r_acc * {{(itp_pkg::VALUE_W-itp_pkg::RADIX_W){1'b0}}, i_cfg.radix})
                 + {{(itp_pkg::VALUE_W-itp_pkg::RADIX_W){1'b0}}, i_cls.dig};
    assign w_used_inc = (r_used < itp_pkg::USED_MAX) ? r_used + 10'd1 : r_used;
    assign w_digit_ok = !i_cls.big && (i_cls.dig < i_cfg.radix);
    assign s_lim = (r_phase == PH_START) ? (i_cfg.max_width != '0) : r_lim;
    assign s_wl  = (r_phase == PH_START) ? i_cfg.max_width : r_wl;

    always_comb begin
        n_phase = r_phase;
        n_minus = r_minus;
        n_acc   = r_acc;
        n_wl    = s_wl;
        n_lim   = s_lim;
        n_any   = r_any;
        n_used  = r_used;
        w_emit  = 1'b0;
        w_src   = r_acc;
        w_res   = '0;
        w_res.pushed_back = 1'b1;
        if (r_phase == PH_START && !i_cls.eoi && (i_cls.is_plus || i_cls.is_minus)) begin
            n_minus = i_cls.is_minus;
            n_used  = w_used_inc;
            n_wl    = s_lim ? s_wl - 8'd1 : s_wl;
            n_phase = PH_SIGNED;
        end else if (i_cls.eoi) begin
            w_emit       = 1'b1;
            w_res.status = r_any ? itp_pkg::STATUS_CONVERTED : itp_pkg::STATUS_END_FIRST;
        end else if ((s_lim && s_wl == '0) || !w_digit_ok) begin
            w_emit       = 1'b1;
            w_res.status = r_any ? itp_pkg::STATUS_CONVERTED : itp_pkg::STATUS_NO_DIGITS;
        end else begin
            n_acc   = w_mac;
            n_any   = 1'b1;
            n_used  = w_used_inc;
            n_phase = PH_DIGITS;
            if (s_lim) begin
                n_wl = s_wl - 8'd1;
                // last digit the width allows ends the field here
                if (s_wl == 8'd1) begin
                    w_emit            = 1'b1;
                    w_src             = w_mac;
                    w_res.status      = itp_pkg::STATUS_CONVERTED;
                    w_res.pushed_back = 1'b0;
                end
            end
        end

        w_val = r_minus ? (32'd0 - w_src) : w_src;
        case (i_cfg.size_mode)
            itp_pkg::SIZE_SHORT: w_val = {16'd0, w_val[15:0]};
            itp_pkg::SIZE_CHAR:  w_val = {24'd0, w_val[7:0]};
            default:             w_val = w_val;
        endcase
        w_res.value      = (w_res.status == itp_pkg::STATUS_CONVERTED) ? w_val : '0;
        w_res.chars_used = n_used;

        if (w_emit) begin
            n_phase = PH_START;
            n_minus = 1'b0;
            n_acc   = '0;
            n_wl    = '0;
            n_lim   = 1'b0;
            n_any   = 1'b0;
            n_used  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_minus <= 1'b0;
            r_acc   <= '0;
            r_wl    <= '0;
            r_lim   <= 1'b0;
            r_any   <= 1'b0;
            r_used  <= '0;
        end else if (o_take) begin
            r_phase <= n_phase;
            r_minus <= n_minus;
            r_acc   <= n_acc;
            r_wl    <= n_wl;
            r_lim   <= n_lim;
            r_any   <= n_any;
            r_used  <= n_used;
        end
    end

    // result queue
    assign w_push   = o_take && w_emit;
    assign w_pop    = i_pop && (r_count != 2'd0);
    assign o_empty  = (r_count == 2'd0);
    assign o_result = r_rq[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 2'd1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_rq[r_wr_ptr] <= w_res;
        end
    end

endmodule

FILE: rtl/integer_text_parser_top.sv
// top level of the integer text parser: configuration registers and the two halves
//
//  channel   | direction | handshake         | payload
//  ----------+-----------+-------------------+------------------------------------------
//  input     | in        | i_push / o_full   | i_char_code, i_end_of_input
//  result    | out       | i_pop / o_empty   | o_status, o_value, o_chars_used, o_pushed_back
//  config    | in        | i_cfg_we          | i_cfg_index, i_cfg_wdata
//
// one character a cycle sustained while the result queue is not full; the back end does one multiply-add per cycle
// a result enters the result queue at the edge at which the back end takes the transaction ending the field
// the front queue and the result queue hold two entries each, so either side may stall
// a full result queue holds the back end, which fills the front queue and raises o_full
// synchronous active-low reset empties both queues and restores the register defaults
module integer_text_parser_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_push,
    output logic                               o_full,
    input  logic [itp_pkg::CHAR_W-1:0]         i_char_code,
    input  logic                               i_end_of_input,
    output logic                               o_empty,
    input  logic                               i_pop,
    output logic [itp_pkg::STATUS_W-1:0]       o_status,
    output logic [itp_pkg::VALUE_W-1:0]        o_value,
    output logic [itp_pkg::USED_W-1:0]         o_chars_used,
    output logic                               o_pushed_back,
    input  logic                               i_cfg_we,
    input  logic [itp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [itp_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    itp_pkg::t_cfg    r_cfg;
    itp_pkg::t_cls    w_cls;
    itp_pkg::t_result w_res;
    logic             w_valid;
    logic             w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.radix     <= itp_pkg::RADIX_RESET;
            r_cfg.max_width <= '0;
            r_cfg.size_mode <= itp_pkg::SIZE_INT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                itp_pkg::CFG_RADIX:     r_cfg.radix     <= i_cfg_wdata[itp_pkg::RADIX_W-1:0];
                itp_pkg::CFG_MAX_WIDTH: r_cfg.max_width <= i_cfg_wdata[itp_pkg::MAXW_W-1:0];
                itp_pkg::CFG_SIZE_MODE: r_cfg.size_mode <= i_cfg_wdata[itp_pkg::SIZE_W-1:0];
                default:                r_cfg           <= r_cfg;
            endcase
        end
    end

    itp_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (i_push),
        .o_full         (o_full),
        .i_char_code    (i_char_code),
        .i_end_of_input (i_end_of_input),
        .o_valid        (w_valid),
        .o_cls          (w_cls),
        .i_take         (w_take)
    );

    itp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (w_valid),
        .i_cls    (w_cls),
        .o_take   (w_take),
        .o_empty  (o_empty),
        .i_pop    (i_pop),
        .o_result (w_res)
    );

    assign o_status      = w_res.status;
    assign o_value       = w_res.value;
    assign o_chars_used  = w_res.chars_used;
    assign o_pushed_back = w_res.pushed_back;

endmodule

FILE: rtl/itp_checker.sv
// port-level checks of the integer text parser and their binding
module itp_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_empty,
    input logic                           i_pop,
    input logic [itp_pkg::STATUS_W-1:0]   o_status,
    input logic [itp_pkg::VALUE_W-1:0]    o_value,
    input logic [itp_pkg::USED_W-1:0]     o_chars_used,
    input logic                           o_pushed_back
);

    // reset leaves no result waiting
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> o_empty)
        else $error("result shown right after reset");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (o_status == itp_pkg::STATUS_CONVERTED ||
                      o_status == itp_pkg::STATUS_NO_DIGITS ||
                      o_status == itp_pkg::STATUS_END_FIRST))
        else $error("undefined status code");

    // failed conversions carry a zero value
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_status != itp_pkg::STATUS_CONVERTED) |-> (o_value == '0))
        else $error("non-zero value on failed conversion");

    // only a width-limited finish consumes the last character
    a_consumed_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !o_pushed_back) |->
            (o_status == itp_pkg::STATUS_CONVERTED && o_chars_used != '0))
        else $error("consumed character without a conversion");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_value) && $stable(o_status)))
        else $error("waiting result changed");

endmodule

bind integer_text_parser_top itp_checker u_itp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_empty       (o_empty),
    .i_pop         (i_pop),
    .o_status      (o_status),
    .o_value       (o_value),
    .o_chars_used  (o_chars_used),
    .o_pushed_back (o_pushed_back)
);

FILE: tb/tb_integer_text_parser_top.sv
// self-checking testbench of the integer text parser: queued stimulus, predictor and checker
`timescale 1ns / 100ps

module tb_integer_text_parser_top;

    localparam int unsigned DRAIN_CYCLES   = 8;
    localparam int unsigned WATCHDOG_LIMIT = 2000;

    typedef enum logic [1:0] {PS_START, PS_SIGNED, PS_DIGITS} t_parse_phase;

    typedef struct {
        logic [itp_pkg::CHAR_W-1:0] ch;
        logic                       eoi;
    } t_char_item;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_push = 1'b0;
    logic                           o_full;
    logic [itp_pkg::CHAR_W-1:0]     i_char_code = '0;
    logic                           i_end_of_input = 1'b0;
    logic                           o_empty;
    logic                           i_pop = 1'b0;
    logic [itp_pkg::STATUS_W-1:0]   o_status;
    logic [itp_pkg::VALUE_W-1:0]    o_value;
    logic [itp_pkg::USED_W-1:0]     o_chars_used;
    logic                           o_pushed_back;
    logic                           i_cfg_we = 1'b0;
    logic [itp_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [itp_pkg::CFG_DATA_W-1:0] i_cfg_wdata = '0;

    integer_text_parser_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (i_push),
        .o_full         (o_full),
        .i_char_code    (i_char_code),
        .i_end_of_input (i_end_of_input),
        .o_empty        (o_empty),
        .i_pop          (i_pop),
        .o_status       (o_status),
        .o_value        (o_value),
        .o_chars_used   (o_chars_used),
        .o_pushed_back  (o_pushed_back),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    always #4 i_clk = ~i_clk;

    // register copies, at their reset values
    logic [itp_pkg::RADIX_W-1:0]  cfg_radix = itp_pkg::RADIX_RESET;
    logic [itp_pkg::MAXW_W-1:0]   cfg_maxw  = '0;
    logic [itp_pkg::SIZE_W-1:0]   cfg_size  = itp_pkg::SIZE_INT;

    // conversion state of the predictor
    t_parse_phase                 cv_phase   = PS_START;
    logic                         cv_minus   = 1'b0;
    logic [itp_pkg::VALUE_W-1:0]  cv_acc     = '0;
    logic [itp_pkg::MAXW_W-1:0]   cv_left    = '0;
    logic                         cv_any     = 1'b0;
    logic [itp_pkg::USED_W-1:0]   cv_used    = '0;
    logic                         cv_limited = 1'b0;

    t_char_item       pend_q[$];
    itp_pkg::t_result conv_results_q[$];
    int unsigned      n_queued = 0;
    int unsigned      n_taken = 0;
    int unsigned      n_errors = 0;
    int unsigned      quiet_cycles = 0;

    function automatic int unsigned digit_value(input logic [itp_pkg::CHAR_W-1:0] ch);
        int unsigned f;
        f = ch;
        if (f >= itp_pkg::CH_LOWER_A) begin
            f = f - itp_pkg::CASE_GAP;
        end
        if (f >= itp_pkg::CH_UPPER_A) begin
            return f - itp_pkg::CH_UPPER_A + itp_pkg::LETTER_BASE;
        end
        if (f >= itp_pkg::CH_ZERO && f <= itp_pkg::CH_NINE) begin
            return f - itp_pkg::CH_ZERO;
        end
        return 32'hFFFF_FFFF;
    endfunction

    // builds the result of the running conversion and starts a fresh one
    function automatic itp_pkg::t_result close_conv(input logic [itp_pkg::STATUS_W-1:0] st,
                                                    input logic pb);
        itp_pkg::t_result            r;
        logic [itp_pkg::VALUE_W-1:0] v;
        v = '0;
        if (st == itp_pkg::STATUS_CONVERTED) begin
            v = cv_minus ? (32'd0 - cv_acc) : cv_acc;
            if (cfg_size == itp_pkg::SIZE_SHORT) begin
                v = v & 32'h0000_FFFF;
            end else if (cfg_size == itp_pkg::SIZE_CHAR) begin
                v = v & 32'h0000_00FF;
            end
        end
        r.status      = st;
        r.value       = v;
        r.chars_used  = cv_used;
        r.pushed_back = pb;
        cv_phase   = PS_START;
        cv_minus   = 1'b0;
        cv_acc     = '0;
        cv_left    = '0;
        cv_any     = 1'b0;
        cv_used    = '0;
        cv_limited = 1'b0;
        return r;
    endfunction

    task automatic parse_char(input logic [itp_pkg::CHAR_W-1:0] ch, input logic eoi);
        int unsigned dv;
        if (cv_phase == PS_START) begin
            if (eoi) begin
                conv_results_q.push_back(close_conv(itp_pkg::STATUS_END_FIRST, 1'b1));
                return;
            end
            cv_limited = (cfg_maxw != '0);
            cv_left    = cfg_maxw;
            if (ch == itp_pkg::CH_MINUS || ch == itp_pkg::CH_PLUS) begin
                cv_minus = (ch == itp_pkg::CH_MINUS);
                if (cv_used < itp_pkg::USED_MAX) begin
                    cv_used = cv_used + 10'd1;
                end
                if (cv_limited) begin
                    cv_left = cv_left - 8'd1;
                end
                cv_phase = PS_SIGNED;
                return;
            end
            cv_phase = PS_SIGNED;
        end
        if (eoi) begin
            conv_results_q.push_back(close_conv(cv_any ? itp_pkg::STATUS_CONVERTED
                                                       : itp_pkg::STATUS_END_FIRST, 1'b1));
        end else if (cv_limited && cv_left == '0) begin
            conv_results_q.push_back(close_conv(cv_any ? itp_pkg::STATUS_CONVERTED
                                                       : itp_pkg::STATUS_NO_DIGITS, 1'b1));
        end else begin
            dv = digit_value(ch);
            if (dv >= cfg_radix) begin
                conv_results_q.push_back(close_conv(cv_any ? itp_pkg::STATUS_CONVERTED
                                                           : itp_pkg::STATUS_NO_DIGITS, 1'b1));
            end else begin
                cv_acc = cv_acc * 32'(cfg_radix) + dv;
                cv_any = 1'b1;
                if (cv_used < itp_pkg::USED_MAX) begin
                    cv_used = cv_used + 10'd1;
                end
                cv_phase = PS_DIGITS;
                if (cv_limited) begin
                    cv_left = cv_left - 8'd1;
                    if (cv_left == '0) begin
                        conv_results_q.push_back(close_conv(itp_pkg::STATUS_CONVERTED, 1'b0));
                    end
                end
            end
        end
    endtask

    // driver: bursts of transactions from the pending queue with random gaps
    int unsigned burst_left = 1;
    int unsigned gap_left = 0;

    always @(posedge i_clk) begin
        logic                       nxt_push;
        logic [itp_pkg::CHAR_W-1:0] nxt_ch;
        logic                       nxt_eoi;
        t_char_item                 it;
        if (!i_rst_n) begin
            i_push <= 1'b0;
        end else begin
            nxt_push = i_push;
            nxt_ch   = i_char_code;
            nxt_eoi  = i_end_of_input;
            if (i_push && !o_full) begin
                parse_char(i_char_code, i_end_of_input);
                n_taken++;
            end
            if (!(i_push && o_full)) begin
                nxt_push = 1'b0;
                nxt_ch   = 8'($urandom);
                nxt_eoi  = 1'($urandom);
                if (gap_left != 0) begin
                    gap_left--;
                end else if (pend_q.size() != 0) begin
                    it       = pend_q.pop_front();
                    nxt_push = 1'b1;
                    nxt_ch   = it.ch;
                    nxt_eoi  = it.eoi;
                    if (burst_left <= 1) begin
                        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                                 : $urandom_range(1, 20);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left--;
                    end
                end
            end
            i_push         <= nxt_push;
            i_char_code    <= nxt_ch;
            i_end_of_input <= nxt_eoi;
        end
    end

    // monitor: pops on a rotating stall pattern and checks every result transaction
    logic [15:0] pop_pat = 16'hFFFF;
    int unsigned pat_timer = 0;

    always @(posedge i_clk) begin
        itp_pkg::t_result want;
        if (!i_rst_n) begin
            i_pop <= 1'b0;
        end else begin
            if (i_pop && !o_empty) begin
                if (conv_results_q.size() == 0) begin
                    $display("%0t: result with none expected, status %0d value %h used %0d",
                             $time, o_status, o_value, o_chars_used);
                    n_errors++;
                end else begin
                    want = conv_results_q.pop_front();
                    if (o_status !== want.status) begin
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, want.status, o_status);
                        n_errors++;
                    end
                    if (o_value !== want.value) begin
                        $display("%0t: value mismatch, expected %h, actual %h",
                                 $time, want.value, o_value);
                        n_errors++;
                    end
                    if (o_chars_used !== want.chars_used) begin
                        $display("%0t: chars_used mismatch, expected %0d, actual %0d",
                                 $time, want.chars_used, o_chars_used);
                        n_errors++;
                    end
                    if (o_pushed_back !== want.pushed_back) begin
                        $display("%0t: pushed_back mismatch, expected %0d, actual %0d",
                                 $time, want.pushed_back, o_pushed_back);
                        n_errors++;
                    end
                end
            end
            if (pat_timer == 0) begin
                pat_timer = $urandom_range(16, 96);
                case ($urandom_range(0, 3))
                    0: begin
                        pop_pat = 16'hFFFF;
                    end
                    1: begin
                        pop_pat = 16'($urandom) | 16'h0001;
                    end
                    2: begin
                        pop_pat = 16'h0001;
                    end
                    default: begin
                        pop_pat = 16'h5555;
                    end
                endcase
            end else begin
                pat_timer--;
                pop_pat = {pop_pat[0], pop_pat[15:1]};
            end
            i_pop <= pop_pat[0];
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_push && !o_full) || (i_pop && !o_empty)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic queue_char(input logic [itp_pkg::CHAR_W-1:0] ch);
        pend_q.push_back('{ch, 1'b0});
        n_queued++;
    endtask

    task automatic queue_end();
        pend_q.push_back('{8'($urandom), 1'b1});
        n_queued++;
    endtask

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            queue_char(8'(s[i]));
        end
    endtask

    // a character that is a valid digit in the current base ('0' when the base is zero), letters in either case
    function automatic logic [itp_pkg::CHAR_W-1:0] digit_char();
        int unsigned dv;
        if (cfg_radix == '0) begin
            return itp_pkg::CH_ZERO;
        end
        dv = $urandom_range(0, cfg_radix - 1);
        if (dv < 10) begin
            return 8'(itp_pkg::CH_ZERO + dv);
        end
        return 8'((($urandom_range(0, 1) == 0) ? itp_pkg::CH_UPPER_A : itp_pkg::CH_LOWER_A)
                  + dv - itp_pkg::LETTER_BASE);
    endfunction

    task automatic queue_number(input int unsigned max_digits);
        int unsigned nd;
        case ($urandom_range(0, 3))
            0: begin
                queue_char(itp_pkg::CH_MINUS);
            end
            1: begin
                queue_char(itp_pkg::CH_PLUS);
            end
            default: begin
            end
        endcase
        nd = $urandom_range(1, max_digits);
        repeat (nd) begin
            queue_char(digit_char());
        end
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                queue_char(8'($urandom_range(0, 255)));
            end
            4, 5, 6: begin
                queue_end();
            end
            default: begin
            end
        endcase
    endtask

    // wait for every transaction to be taken and answered, then let the pipeline drain
    task automatic settle();
        while (n_taken != n_queued || conv_results_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic random_phase(input int unsigned n_items);
        int unsigned first;
        first = n_queued;
        while (n_queued - first < n_items) begin
            if ($urandom_range(0, 9) < 7) begin
                queue_number(($urandom_range(0, 7) == 0) ? 40 : 8);
            end else if ($urandom_range(0, 3) == 0) begin
                queue_end();
            end else begin
                queue_char(8'($urandom_range(0, 255)));
            end
        end
        queue_end();
        settle();
    endtask

    task automatic set_config(input logic [itp_pkg::RADIX_W-1:0] r,
                              input logic [itp_pkg::MAXW_W-1:0] w,
                              input logic [itp_pkg::SIZE_W-1:0] s);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= itp_pkg::CFG_RADIX;
        i_cfg_wdata <= {3'b000, r};
        @(posedge i_clk);
        i_cfg_index <= itp_pkg::CFG_MAX_WIDTH;
        i_cfg_wdata <= w;
        @(posedge i_clk);
        i_cfg_index <= itp_pkg::CFG_SIZE_MODE;
        i_cfg_wdata <= {6'b000000, s};
        @(posedge i_clk);
        i_cfg_we  <= 1'b0;
        cfg_radix = r;
        cfg_maxw  = w;
        cfg_size  = s;
    endtask

    initial begin
        logic [itp_pkg::RADIX_W-1:0] r;
        logic [itp_pkg::MAXW_W-1:0]  w;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults: end at start, end after a sign, signs, terminators
        queue_end();
        queue_text("-");
        queue_end();
        queue_text("+12x-42");
        queue_end();
        settle();

        // width reached by a digit, folded letters, digit equal to the base
        set_config(5'd16, 8'd3, itp_pkg::SIZE_SHORT);
        queue_text("-FfG");
        queue_end();
        settle();

        // sign takes the whole width, end right after a sign with no width left
        set_config(5'd2, 8'd1, itp_pkg::SIZE_CHAR);
        queue_text("-1-");
        queue_end();
        queue_text("1");
        settle();

        // base beyond 16, high byte codes
        set_config(5'd31, 8'd255, itp_pkg::SIZE_WIDE);
        queue_text("~Uv");
        queue_char(8'h00);
        queue_char(8'hFF);
        queue_end();
        settle();

        set_config(5'd16, 8'd255, itp_pkg::SIZE_WIDE);
        random_phase(20);
        set_config(5'd2, 8'd0, itp_pkg::SIZE_CHAR);
        random_phase(20);

        for (int p = 0; p < 6; p++) begin
            case ($urandom_range(0, 9))
                0: begin
                    r = 5'($urandom_range(0, 1));
                end
                1: begin
                    r = 5'($urandom_range(17, 31));
                end
                default: begin
                    r = 5'($urandom_range(2, 16));
                end
            endcase
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    w = 8'd0;
                end
                4, 5, 6, 7: begin
                    w = 8'($urandom_range(1, 6));
                end
                8: begin
                    w = 8'd255;
                end
                default: begin
                    w = 8'($urandom_range(0, 255));
                end
            endcase
            set_config(r, w, 2'($urandom_range(0, 3)));
            random_phase(15);
        end

        // one field long enough to saturate the consumed count
        set_config(5'd10, 8'd0, itp_pkg::SIZE_INT);
        queue_char(itp_pkg::CH_MINUS);
        repeat (1023) begin
            queue_char(digit_char());
        end
        queue_end();
        settle();

        if (n_errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/itp_pkg.sv
rtl/itp_front.sv
rtl/itp_back.sv
rtl/integer_text_parser_top.sv
rtl/itp_checker.sv
tb/tb_integer_text_parser_top.sv
